@@ hw/rtl/cfsr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsr_pkg
// Shared types and constants of the checksum frame sync receiver.
// ----------------------------------------------------------------------------
package cfsr_pkg;

    localparam int FRAME_LEN_DEF   = 11;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 2'd1;

    localparam logic [7:0] HEADER_RST     = 8'h55;
    localparam logic [7:0] END_MARKER_RST = 8'h00;

    localparam logic KIND_FRAME_BYTE = 1'b0;
    localparam logic KIND_REJECT     = 1'b1;

    // received word as carried through the queue
    typedef struct packed {
        logic [7:0] data;
    } t_rx_word;

endpackage

@@ hw/rtl/cfsr_front.sv @@
// ----------------------------------------------------------------------------
// cfsr_front
// Configuration registers and intake: holds the header and end marker values
// and hands each received word to the queue.
// ----------------------------------------------------------------------------
module cfsr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic [7:0]                     i_rx_byte,
    output cfsr_pkg::t_rx_word             o_rx_word,
    output logic [7:0]                     o_header,
    output logic [7:0]                     o_end_marker
);

    logic [7:0] r_header;
    logic [7:0] r_end_marker;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header     <= cfsr_pkg::HEADER_RST;
            r_end_marker <= cfsr_pkg::END_MARKER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cfsr_pkg::REG_HEADER:     r_header     <= i_cfg_data;
                cfsr_pkg::REG_END_MARKER: r_end_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_rx_word.data = i_rx_byte;
    assign o_header       = r_header;
    assign o_end_marker   = r_end_marker;

endmodule

@@ hw/rtl/cfsr_queue.sv @@
// ----------------------------------------------------------------------------
// cfsr_queue
// Short word queue between intake and the frame engine.
// ----------------------------------------------------------------------------
module cfsr_queue #(
    parameter int DEPTH = cfsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cfsr_pkg::t_rx_word i_data,
    output logic               o_full,
    input  logic               i_pop,
    output cfsr_pkg::t_rx_word o_data,
    output logic               o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cfsr_pkg::t_rx_word r_slot [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/cfsr_engine.sv @@
// ----------------------------------------------------------------------------
// cfsr_engine
// Frame store, checksum check, result emission and resynchronization.
// Holds one result word in an output register.
// ----------------------------------------------------------------------------
module cfsr_engine #(
    parameter int FRAME_LEN = cfsr_pkg::FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfsr_pkg::t_rx_word i_q_data,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [7:0]         i_header,
    input  logic [7:0]         i_end_marker,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_end,
    output logic               o_result_kind,
    output logic [31:0]        o_total_frames,
    output logic [31:0]        o_lost_frames
);

    localparam int AW = $clog2(FRAME_LEN);
    localparam logic [AW-1:0] LAST = AW'(FRAME_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT_RD,
        S_EMIT_WR,
        S_REJECT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COPY_RD,
        S_COPY_WR
    } t_state;

    cfsr_pkg::t_rx_word mem [FRAME_LEN];
    cfsr_pkg::t_rx_word r_rdata;

    t_state        r_state;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_src;
    logic [AW-1:0] r_dst;
    logic [7:0]    r_sum;
    logic [7:0]    r_byte0;
    logic [31:0]   r_total;
    logic [31:0]   r_lost;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_end;
    logic          r_out_kind;
    logic [31:0]   r_out_total;
    logic [31:0]   r_out_lost;

    logic               out_free;
    logic               take;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    cfsr_pkg::t_rx_word mem_wdata;
    logic [AW-1:0]      mem_raddr;

    assign out_free = !r_out_valid || i_pop;
    assign take     = (r_state == S_IDLE) && !i_q_empty;
    assign o_q_pop  = take;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill;
        mem_wdata = i_q_data;
        if (take) begin
            mem_we = 1'b1;
        end else if (r_state == S_COPY_WR) begin
            mem_we    = 1'b1;
            mem_waddr = r_dst;
            mem_wdata = r_rdata;
        end
    end

    // hold the read address while emission stalls so the read word stays put
    always_comb begin
        unique case (r_state)
            S_EMIT_RD, S_EMIT_WR:              mem_raddr = r_idx;
            S_SCAN_RD, S_SCAN_CHK,
            S_COPY_RD, S_COPY_WR:              mem_raddr = r_src;
            default:                           mem_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_sum       <= '0;
            r_byte0     <= '0;
            r_total     <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (r_fill == LAST) begin
                            r_total <= r_total + 32'd1;
                            r_idx   <= '0;
                            // compare against the header value in force now
                            if ((r_byte0 == i_header) && (r_sum == i_q_data.data)) begin
                                r_state <= S_EMIT_RD;
                            end else begin
                                r_lost  <= r_lost + 32'd1;
                                r_state <= S_REJECT;
                            end
                        end else begin
                            if (r_fill == '0) begin
                                r_byte0 <= i_q_data.data;
                            end
                            r_sum  <= r_sum + i_q_data.data;
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= (r_idx == LAST) ? i_end_marker : r_rdata.data;
                        r_out_end   <= (r_idx == LAST);
                        r_out_kind  <= cfsr_pkg::KIND_FRAME_BYTE;
                        r_out_total <= r_total;
                        r_out_lost  <= r_lost;
                        if (r_idx == LAST) begin
                            r_fill  <= '0;
                            r_sum   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_REJECT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= '0;
                        r_out_end   <= 1'b1;
                        r_out_kind  <= cfsr_pkg::KIND_REJECT;
                        r_out_total <= r_total;
                        r_out_lost  <= r_lost;
                        r_src       <= AW'(1);
                        r_sum       <= '0;
                        r_state     <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (r_rdata.data == i_header) begin
                        r_dst   <= '0;
                        r_state <= S_COPY_RD;
                    end else if (r_src == LAST) begin
                        // no header left: drop the whole store
                        r_fill  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_src   <= r_src + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_COPY_RD: begin
                    r_state <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (r_dst == '0) begin
                        r_byte0 <= r_rdata.data;
                    end
                    r_sum <= r_sum + r_rdata.data;
                    r_dst <= r_dst + 1'b1;
                    if (r_src == LAST) begin
                        r_fill  <= r_dst + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_src   <= r_src + 1'b1;
                        r_state <= S_COPY_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_frame_byte   = r_out_byte;
    assign o_frame_end    = r_out_end;
    assign o_result_kind  = r_out_kind;
    assign o_total_frames = r_out_total;
    assign o_lost_frames  = r_out_lost;

endmodule

@@ hw/rtl/checksum_frame_sync_receiver_top.sv @@
// ----------------------------------------------------------------------------
// checksum_frame_sync_receiver_top
// Gathers received words into frames, checks header and additive checksum,
// emits valid frames word by word and resynchronizes on rejected frames.
//
// Usage:
//   Input channel: present i_rx_byte with i_push; a word is taken when o_full
//   is low. Words land in a short queue and the frame engine drains them at
//   one word per cycle while it is collecting a frame.
//   Result channel: a result sits on the o_* payload ports while o_empty is
//   low; i_pop takes it. A valid frame yields FRAME_LEN results, a rejected
//   frame yields one.
//   Configuration: i_cfg_valid writes i_cfg_data to register i_cfg_index
//   (0 header value, 1 end marker); o_cfg_ready is always high. Write only
//   while the block is idle.
//   Sequencing: a word that does not complete a frame is stored and added to
//   the sum. A valid frame is emitted word by word, each word read from the
//   frame store and then registered as a result. A rejected frame emits its
//   result, then scans the store for the next header and moves the words from
//   there down, with no input taken. The result register holds one word ahead.
//   Stalls: while i_pop stays low the engine holds at its next result; input
//   words still queue up to QUEUE_DEPTH before o_full rises.
//   Reset: counters and fill level clear; registers take their reset values.
// ----------------------------------------------------------------------------
module checksum_frame_sync_receiver_top #(
    parameter int FRAME_LEN   = cfsr_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = cfsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [7:0]                     o_frame_byte,
    output logic                           o_frame_end,
    output logic                           o_result_kind,
    output logic [31:0]                    o_total_frames,
    output logic [31:0]                    o_lost_frames
);

    cfsr_pkg::t_rx_word rx_word;
    cfsr_pkg::t_rx_word q_data;
    logic               q_empty;
    logic               q_pop;
    logic [7:0]         header;
    logic [7:0]         end_marker;

    cfsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx_byte    (i_rx_byte),
        .o_rx_word    (rx_word),
        .o_header     (header),
        .o_end_marker (end_marker)
    );

    cfsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (rx_word),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    cfsr_engine #(
        .FRAME_LEN (FRAME_LEN)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_data),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_header       (header),
        .i_end_marker   (end_marker),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_frame_byte   (o_frame_byte),
        .o_frame_end    (o_frame_end),
        .o_result_kind  (o_result_kind),
        .o_total_frames (o_total_frames),
        .o_lost_frames  (o_lost_frames)
    );

endmodule
